[design/mpda_pkg.sv]
// Shared types and constants for the mouse packet delta accumulator.
package mpda_pkg;

   // Default width of the X and Y running totals.
   localparam int ACC_WIDTH_DEFAULT = 16;

   // Width of the reported total and its clamp limits.
   localparam int REPORT_WIDTH = 16;
   localparam int REPORT_MAX   = 32767;
   localparam int REPORT_MIN   = -32768;

   // Header byte bit positions.
   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   localparam int ACTION_WIDTH = 2;
   localparam int BYTE_WIDTH   = 8;

   // Request kinds carried in tuser; the fourth code is unused and ignored.
   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_BYTE   = 2'd0,
      ACT_READ_X = 2'd1,
      ACT_READ_Y = 2'd2
   } action_type;

endpackage

[design/mouse_packet_delta_accumulator.sv]
// Top level of the mouse packet delta accumulator.
//
// The request channel carries one beat per received mouse byte or per
// read-and-clear request: req_tuser selects the kind and req_tdata holds
// the received byte. Bytes are assembled into three-byte motion packets
// (header, X, Y); a header without its always-one bit is dropped so the
// stream resynchronizes. Each complete packet adds its 9-bit X and Y deltas
// to two saturating totals of ACC_WIDTH bits.
// A read-and-clear request returns one beat on the response channel with
// the chosen total, clamped to 16 bits, and zeroes that total. Byte beats
// and the unused request kind produce no response.
// A beat is taken into an input register and processed from there; a read's
// response lands in the output register in the cycle after it is processed.
// One beat is accepted every cycle unless a read is held in the input register.
// When the receiver stalls, a pending response holds in the output register;
// byte beats keep flowing, and a read waits in the input register, which
// then drops req_tready until the response is taken.
// Reset clears the packet position, sign bits, held X byte, both totals and
// all valid flags.
module mouse_packet_delta_accumulator #(
   parameter int ACC_WIDTH = mpda_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mpda_pkg::BYTE_WIDTH-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic [mpda_pkg::ACTION_WIDTH-1:0]   req_tuser,   // [1:0] action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mpda_pkg::REPORT_WIDTH-1:0]   rsp_tdata    // [15:0] motion_total
);

   localparam int RPT_W = (ACC_WIDTH > mpda_pkg::REPORT_WIDTH) ?
                          ACC_WIDTH : mpda_pkg::REPORT_WIDTH;
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [RPT_W-1:0] RPT_MAX = RPT_W'(mpda_pkg::REPORT_MAX);
   localparam logic signed [RPT_W-1:0] RPT_MIN = RPT_W'(mpda_pkg::REPORT_MIN);

   typedef enum logic [1:0] {
      POS_HEADER = 2'd0,
      POS_X      = 2'd1,
      POS_Y      = 2'd2
   } position_type;

   // Input register.
   logic                                in_valid_ff, in_valid_in;
   mpda_pkg::action_type                in_action_ff;
   logic [mpda_pkg::BYTE_WIDTH-1:0]     in_byte_ff;

   // Packet and accumulator state.
   position_type                        pos_ff, pos_in;
   logic [1:0]                          sign_ff, sign_in;
   logic [mpda_pkg::BYTE_WIDTH-1:0]     held_x_ff, held_x_in;
   logic signed [ACC_WIDTH-1:0]         total_x_ff, total_x_in;
   logic signed [ACC_WIDTH-1:0]         total_y_ff, total_y_in;

   // Output register.
   logic                                out_valid_ff, out_valid_in;
   logic [mpda_pkg::REPORT_WIDTH-1:0]   out_data_ff, out_data_in;

   logic                                is_read;
   logic                                advance;
   logic signed [8:0]                   delta_x, delta_y;
   logic signed [ACC_WIDTH:0]           sum_x, sum_y;
   logic signed [ACC_WIDTH-1:0]         sat_x, sat_y;
   logic signed [ACC_WIDTH-1:0]         read_total;
   logic signed [RPT_W-1:0]             read_wide;
   logic signed [RPT_W-1:0]             read_clamped;

   assign is_read = (in_action_ff == mpda_pkg::ACT_READ_X) ||
                    (in_action_ff == mpda_pkg::ACT_READ_Y);

   // A read needs the output register free; other beats always move on.
   assign advance    = in_valid_ff && (!is_read || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      delta_x = {sign_ff[0], held_x_ff};
      delta_y = {sign_ff[1], in_byte_ff};
      sum_x   = (ACC_WIDTH+1)'(total_x_ff) + (ACC_WIDTH+1)'(delta_x);
      sum_y   = (ACC_WIDTH+1)'(total_y_ff) + (ACC_WIDTH+1)'(delta_y);

      // The top two sum bits disagree only when the add left the range.
      if (sum_x[ACC_WIDTH] != sum_x[ACC_WIDTH-1]) begin
         sat_x = sum_x[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_x = sum_x[ACC_WIDTH-1:0];
      end
      if (sum_y[ACC_WIDTH] != sum_y[ACC_WIDTH-1]) begin
         sat_y = sum_y[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_y = sum_y[ACC_WIDTH-1:0];
      end

      read_total = (in_action_ff == mpda_pkg::ACT_READ_X) ? total_x_ff : total_y_ff;
      read_wide  = RPT_W'(read_total);
      if (read_wide > RPT_MAX) begin
         read_clamped = RPT_MAX;
      end else if (read_wide < RPT_MIN) begin
         read_clamped = RPT_MIN;
      end else begin
         read_clamped = read_wide;
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      pos_in       = pos_ff;
      sign_in      = sign_ff;
      held_x_in    = held_x_ff;
      total_x_in   = total_x_ff;
      total_y_in   = total_y_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         case (in_action_ff)
            mpda_pkg::ACT_READ_X: begin
               out_valid_in = 1'b1;
               out_data_in  = read_clamped[mpda_pkg::REPORT_WIDTH-1:0];
               total_x_in   = '0;
            end
            mpda_pkg::ACT_READ_Y: begin
               out_valid_in = 1'b1;
               out_data_in  = read_clamped[mpda_pkg::REPORT_WIDTH-1:0];
               total_y_in   = '0;
            end
            mpda_pkg::ACT_BYTE: begin
               case (pos_ff)
                  POS_X: begin
                     held_x_in = in_byte_ff;
                     pos_in    = POS_Y;
                  end
                  POS_Y: begin
                     total_x_in = sat_x;
                     total_y_in = sat_y;
                     pos_in     = POS_HEADER;
                  end
                  default: begin
                     if (in_byte_ff[mpda_pkg::HDR_SYNC_BIT]) begin
                        sign_in = {in_byte_ff[mpda_pkg::HDR_YSIGN_BIT],
                                   in_byte_ff[mpda_pkg::HDR_XSIGN_BIT]};
                        pos_in  = POS_X;
                     end else begin
                        pos_in  = POS_HEADER;
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_HEADER;
         sign_ff      <= '0;
         held_x_ff    <= '0;
         total_x_ff   <= '0;
         total_y_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         sign_ff      <= sign_in;
         held_x_ff    <= held_x_in;
         total_x_ff   <= total_x_in;
         total_y_ff   <= total_y_in;
      end
   end

   // Payload registers load only with a new beat or a read response and need no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= mpda_pkg::action_type'(req_tuser);
         in_byte_ff   <= req_tdata;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // A read of the X total leaves it cleared.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_action_ff == mpda_pkg::ACT_READ_X |=> total_x_ff == '0)
      else $error("X total not cleared after read");

   // A read of the Y total leaves it cleared.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_action_ff == mpda_pkg::ACT_READ_Y |=> total_y_ff == '0)
      else $error("Y total not cleared after read");

   // A response appears only after a read request has been processed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance && is_read))
      else $error("response without a read request");

endmodule
